// ===== src/cross_morphology_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Cross morphology filter assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CROSS_MORPHOLOGY_FILTER_MACROS_SVH
`define CROSS_MORPHOLOGY_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
// Assertion on an explicit clock and active-low reset.
`define CMF_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cross morphology filter assertion failed");
// Assertion on the block clock and reset.
`define CMF_ASSERT(lbl, prop) `CMF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define CMF_ASSERT_CLK(lbl, clk, rst_n, prop)
`define CMF_ASSERT(lbl, prop)
`endif
`endif

// ===== src/cmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Cross morphology filter package
// Shared widths, register indexes and payload types.
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int unsigned CMF_MAX_WIDTH  = 1024;
  localparam int unsigned CMF_MAX_HEIGHT = 4096;

  localparam int unsigned CMF_PIX_W     = 8;
  localparam int unsigned CMF_FWIDTH_W  = 11;
  localparam int unsigned CMF_FHEIGHT_W = 13;

  localparam logic [CMF_PIX_W-1:0]     CMF_PIX_MAX     = 8'd255;
  localparam logic [CMF_FWIDTH_W-1:0]  CMF_FWIDTH_RST  = 11'd1024;
  localparam logic [CMF_FHEIGHT_W-1:0] CMF_FHEIGHT_RST = 13'd1024;

  // Configuration port
  localparam int unsigned CMF_CFG_IDX_W  = 2;
  localparam int unsigned CMF_CFG_DATA_W = 13;

  localparam logic [CMF_CFG_IDX_W-1:0] CMF_REG_MODE   = 2'd0;
  localparam logic [CMF_CFG_IDX_W-1:0] CMF_REG_WIDTH  = 2'd1;
  localparam logic [CMF_CFG_IDX_W-1:0] CMF_REG_HEIGHT = 2'd2;

  // At most three results per input pixel
  localparam int unsigned CMF_MAX_RES   = 3;
  localparam int unsigned CMF_RES_CNT_W = 2;

  // Position of a pixel within the frame
  typedef struct packed {
    logic first_col;
    logic col_ge2;
    logic last_col;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
  } cmf_pos_t;

  // Neighbourhood gathered for one pixel
  typedef struct packed {
    logic [CMF_PIX_W-1:0] px;        // incoming pixel (r, c)
    logic [CMF_PIX_W-1:0] ctr;       // (r-1, c)
    logic [CMF_PIX_W-1:0] up;        // (r-2, c)
    logic [CMF_PIX_W-1:0] right;     // (r-1, c+1)
    logic [CMF_PIX_W-1:0] left;      // (r-1, c-1)
    logic [CMF_PIX_W-1:0] prev_px;   // (r, c-1)
    logic [CMF_PIX_W-1:0] prev2_px;  // (r, c-2)
  } cmf_win_t;

  typedef struct packed {
    logic [CMF_PIX_W-1:0] pixel;
    logic                 frame_end;
  } cmf_res_t;

endpackage

// ===== src/cmf_intf.sv =====
// ----------------------------------------------------------------------------
// Cross morphology filter channel interfaces
// Valid/ready channels for pixels in, results out and configuration writes.
// ----------------------------------------------------------------------------
interface cmf_pix_if import cmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMF_PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cmf_res_if import cmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMF_PIX_W-1:0] pixel_out;
  logic                 frame_end;
  logic                 run_last;

  modport source (output valid, output pixel_out, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input frame_end, input run_last,
                  output ready);
endinterface

interface cmf_cfg_if import cmf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMF_CFG_IDX_W-1:0]  index;
  logic [CMF_CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/cmf_line_ram.sv =====
// ----------------------------------------------------------------------------
// Cross morphology filter line store
// One row of pixels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmf_line_ram import cmf_pkg::*; #(
  parameter int unsigned DEPTH  = CMF_MAX_WIDTH,
  parameter int unsigned DATA_W = CMF_PIX_W,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cmf_kernel.sv =====
// ----------------------------------------------------------------------------
// Cross morphology filter kernel
// Forms the up to three results one pixel releases and packs them in order.
// ----------------------------------------------------------------------------
module cmf_kernel import cmf_pkg::*; (
  input  logic                             mode_i,
  input  cmf_win_t                         win_i,
  input  cmf_pos_t                         pos_i,
  output cmf_res_t [CMF_MAX_RES-1:0]       res_o,
  output logic     [CMF_RES_CNT_W-1:0]     num_o
);

  logic [CMF_PIX_W-1:0] key;
  logic                 hit_a, hit_b, hit_c;
  logic                 va, vb, vc;
  cmf_res_t             res_a, res_b, res_c;

  assign key = mode_i ? CMF_PIX_MAX : '0;

  // Result for the pixel one row above the incoming one.
  assign hit_a = (win_i.ctr == key) || (win_i.px == key)
              || (pos_i.row_ge2 && (win_i.up == key))
              || (!pos_i.first_col && (win_i.left == key))
              || (!pos_i.last_col && (win_i.right == key));

  // Last row: result for the pixel to the left of the incoming one.
  assign hit_b = (win_i.prev_px == key) || (win_i.px == key)
              || (pos_i.row_ge1 && (win_i.left == key))
              || (pos_i.col_ge2 && (win_i.prev2_px == key));

  // Last pixel of the frame: result for the incoming pixel itself.
  assign hit_c = (win_i.px == key)
              || (pos_i.row_ge1 && (win_i.ctr == key))
              || (!pos_i.first_col && (win_i.prev_px == key));

  assign va = pos_i.row_ge1;
  assign vb = pos_i.last_row && !pos_i.first_col;
  assign vc = pos_i.last_row && pos_i.last_col;

  always_comb begin
    res_a.pixel     = hit_a ? key : win_i.ctr;
    res_a.frame_end = 1'b0;
    res_b.pixel     = hit_b ? key : win_i.prev_px;
    res_b.frame_end = 1'b0;
    res_c.pixel     = hit_c ? key : win_i.px;
    res_c.frame_end = 1'b1;

    if (va) begin
      res_o[0] = res_a;
    end else if (vb) begin
      res_o[0] = res_b;
    end else begin
      res_o[0] = res_c;
    end
    res_o[1] = (va && vb) ? res_b : res_c;
    res_o[2] = res_c;

    num_o = {1'b0, va} + {1'b0, vb} + {1'b0, vc};
  end

endmodule

// ===== src/cmf_result_buf.sv =====
// ----------------------------------------------------------------------------
// Cross morphology filter result buffer
// Holds the results of one pixel and hands them out one per transaction.
// ----------------------------------------------------------------------------
module cmf_result_buf import cmf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  cmf_res_t [CMF_MAX_RES-1:0]   res_i,
  input  logic     [CMF_RES_CNT_W-1:0] num_i,
  output logic                         free_o,
  cmf_res_if.source                    out_o
);

  cmf_res_t [CMF_MAX_RES-1:0]   res_q;
  logic     [CMF_RES_CNT_W-1:0] num_q, idx_q;
  logic                         last;
  logic                         out_hs;

  assign last   = (idx_q == (num_q - CMF_RES_CNT_W'(1)));
  assign out_hs = out_o.valid && out_o.ready;
  assign free_o = (num_q == '0) || (out_o.ready && last);

  assign out_o.valid     = (num_q != '0);
  assign out_o.pixel_out = res_q[idx_q].pixel;
  assign out_o.frame_end = res_q[idx_q].frame_end;
  assign out_o.run_last  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      num_q <= num_i;
      idx_q <= '0;
    end else if (out_hs) begin
      if (last) begin
        num_q <= '0;
      end else begin
        idx_q <= idx_q + CMF_RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== src/cross_morphology_filter.sv =====
// ----------------------------------------------------------------------------
// Cross morphology filter: 4-connected dilate/erode on a raster pixel stream
// The first result of a pixel is offered once the pixel has passed the S1 register and
// been loaded into the result buffer; the load waits until the buffer is free.
// Throughput: one pixel per cycle while the output takes results; on the last row a pixel
// can yield up to three results, so the single-result output port sets the pace there.
// Reset: counters and registers (mode 0, 1024 x 1024) reset at once; no line store clearing.
// ----------------------------------------------------------------------------
`include "cross_morphology_filter_macros.svh"

module cross_morphology_filter import cmf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = CMF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = CMF_MAX_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cmf_cfg_if.sink   cfg_i,
  cmf_pix_if.sink   in_i,
  cmf_res_if.source out_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  // The datapath is a single stage. An accepted pixel is captured in the
  // S1 register together with the line store read data for its column; the
  // kernel then forms its results combinationally and they are loaded into
  // the result buffer, which drives the output port. The line stores are
  // written with the pixel as it leaves S1, so a pixel accepted in that
  // same cycle may read a stale entry; bypass flags captured with it select
  // the history registers instead.

  // --------------------------------------------------------------------------
  // Configuration registers and position counters
  // --------------------------------------------------------------------------
  logic                     mode_q;
  logic [CMF_FWIDTH_W-1:0]  fwidth_q;
  logic [CMF_FHEIGHT_W-1:0] fheight_q;
  logic [COL_W-1:0]         col_q, col_last;
  logic [ROW_W-1:0]         row_q, row_last;
  logic                     cfg_acc, in_acc;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_acc      = in_i.valid && in_i.ready;

  // Last column and row index of the frame, with the geometry registers
  // saturated to 1..MAX_WIDTH and 1..MAX_HEIGHT.
  always_comb begin
    if (fwidth_q == '0) begin
      col_last = '0;
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(fwidth_q - 1'b1);
    end

    if (fheight_q == '0) begin
      row_last = '0;
    end else if (32'(fheight_q) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(fheight_q - 1'b1);
    end
  end

  // The user must write configuration only while the block is idle, so that a write and a
  // pixel transaction never fall in the same cycle; the block itself does not enforce this.
  // A geometry write starts a new frame with the next pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      fwidth_q  <= CMF_FWIDTH_RST;
      fheight_q <= CMF_FHEIGHT_RST;
      col_q     <= '0;
      row_q     <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        CMF_REG_MODE: begin
          mode_q <= cfg_i.data[0];
        end
        CMF_REG_WIDTH: begin
          fwidth_q <= cfg_i.data[CMF_FWIDTH_W-1:0];
          col_q    <= '0;
          row_q    <= '0;
        end
        CMF_REG_HEIGHT: begin
          fheight_q <= cfg_i.data[CMF_FHEIGHT_W-1:0];
          col_q     <= '0;
          row_q     <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (col_q == col_last) begin
        col_q <= '0;
        row_q <= (row_q == row_last) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input stage (S1)
  // --------------------------------------------------------------------------
  logic                 s1_valid_q, s1_adv;
  logic [CMF_PIX_W-1:0] s1_px_q;
  logic [COL_W-1:0]     s1_col_q;
  cmf_pos_t             s1_pos_d, s1_pos_q;
  logic                 s1_byp_n0_d, s1_byp_n0_q;
  logic                 s1_byp_n1_d, s1_byp_n1_q;
  logic [COL_W-1:0]     raddr_right;

  // History of the pixels that have left S1: the two latest pixels and the
  // row-above value of the latest one.
  logic [CMF_PIX_W-1:0] hist_px1_q, hist_px2_q, hist_ctr1_q;

  assign s1_pos_d.first_col = (col_q == '0);
  assign s1_pos_d.col_ge2   = (col_q > COL_W'(1));
  assign s1_pos_d.last_col  = (col_q == col_last);
  assign s1_pos_d.row_ge1   = (row_q != '0);
  assign s1_pos_d.row_ge2   = (row_q > ROW_W'(1));
  assign s1_pos_d.last_row  = (row_q == row_last);

  // The right-hand neighbour is read one column ahead; it is not used on
  // the last column, where the address is held in range instead.
  assign raddr_right = s1_pos_d.last_col ? col_q : col_q + COL_W'(1);

  // A pixel leaving S1 writes its column in the same cycle as the reads of
  // the incoming pixel. This only collides on frames one or two pixels wide.
  assign s1_byp_n0_d = s1_adv && (col_q == s1_col_q);
  assign s1_byp_n1_d = s1_adv && (raddr_right == s1_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q     <= in_i.pixel_in;
      s1_col_q    <= col_q;
      s1_pos_q    <= s1_pos_d;
      s1_byp_n0_q <= s1_byp_n0_d;
      s1_byp_n1_q <= s1_byp_n1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: the newer row is kept twice so that the centre and the
  // right-hand column can be read in the same cycle.
  // --------------------------------------------------------------------------
  logic [CMF_PIX_W-1:0] newer_ctr_rd, newer_right_rd, older_rd;
  cmf_win_t             win;

  cmf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (CMF_PIX_W)
  ) u_newer_ctr (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (newer_ctr_rd)
  );

  cmf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (CMF_PIX_W)
  ) u_newer_right (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (raddr_right),
    .rdata_o (newer_right_rd)
  );

  // The older row takes the newer row's old entry as the pixel moves on.
  cmf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (CMF_PIX_W)
  ) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (win.ctr),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  // Neighbourhood of the pixel in S1. Left and earlier pixels of the same
  // row come from the history registers rather than from the line stores.
  assign win.px       = s1_px_q;
  assign win.ctr      = s1_byp_n0_q ? hist_px1_q  : newer_ctr_rd;
  assign win.up       = s1_byp_n0_q ? hist_ctr1_q : older_rd;
  assign win.right    = s1_byp_n1_q ? hist_px1_q  : newer_right_rd;
  assign win.left     = hist_ctr1_q;
  assign win.prev_px  = hist_px1_q;
  assign win.prev2_px = hist_px2_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hist_px1_q  <= s1_px_q;
      hist_px2_q  <= hist_px1_q;
      hist_ctr1_q <= win.ctr;
    end
  end

  // --------------------------------------------------------------------------
  // Kernel and result buffer
  // --------------------------------------------------------------------------
  cmf_res_t [CMF_MAX_RES-1:0]   k_res;
  logic     [CMF_RES_CNT_W-1:0] k_num;
  logic                         rb_free, rb_load;

  cmf_kernel u_kernel (
    .mode_i (mode_q),
    .win_i  (win),
    .pos_i  (s1_pos_q),
    .res_o  (k_res),
    .num_o  (k_num)
  );

  // A pixel that releases no result (first row of a taller frame) leaves S1
  // without waiting for the result buffer.
  assign s1_adv     = s1_valid_q && ((k_num == '0) || rb_free);
  assign rb_load    = s1_adv && (k_num != '0);
  assign in_i.ready = !s1_valid_q || s1_adv;

  cmf_result_buf u_result_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (rb_load),
    .res_i  (k_res),
    .num_i  (k_num),
    .free_o (rb_free),
    .out_o  (out_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CMF_ASSERT(a_col_in_frame, col_q <= col_last)
  `CMF_ASSERT(a_frame_end_closes_run,
      (out_o.valid && out_o.ready && out_o.frame_end) |-> out_o.run_last)
  `CMF_ASSERT(a_bypass_narrow_frame, (s1_valid_q && s1_byp_n0_q) |-> (col_last == '0))

endmodule
